// ===== rtl/ilir_pkg.sv =====
// Package for the indexed list insert/remove unit: sizes, codes and cell command type.
package ilir_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // Fixed field widths of the item and result channels
    localparam int OP_W     = 2;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    // Derived widths
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                  ins;
        logic                  rem;
        logic [IDX_W-1:0]      pos;
        logic [DATA_WIDTH-1:0] value;
    } t_cell_cmd;

endpackage

// ===== rtl/ilir_if.sv =====
// Handshake interfaces for the operation and result channels.
interface ilir_in_if;
    import ilir_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output op, output position, output value, input ready);
    modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface ilir_out_if;
    import ilir_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  removed_value;
    logic [LEN_W-1:0]    length;

    modport source (output valid, output status, output removed_value, output length,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input length,
                    output ready);
endinterface

// ===== rtl/indexed_list_insert_remove_unit.sv =====
// Indexed list insert/remove unit: top level with count control and the chain of cells.
// The result of an accepted operation is registered in the output register in the cycle after it is accepted.
// Throughput: one operation per cycle while results are taken; every cell shifts at once.
// A waiting result holds off the next operation until it is transferred.
// Reset (synchronous, active low) empties the list and clears the output valid;
// element storage is not cleared, positions at or above the length are never read.
module indexed_list_insert_remove_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    ilir_in_if.sink    i_in,
    ilir_out_if.source o_out
);
    import ilir_pkg::*;

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [STATUS_W-1:0]   n_status;
    logic [VALUE_W-1:0]    r_removed;
    logic [VALUE_W-1:0]    n_removed;

    logic                  w_accept;
    logic                  w_do;
    logic [CMP_W-1:0]      w_pos_x;
    logic [CMP_W-1:0]      w_cnt_x;
    logic                  w_full;
    t_cell_cmd             w_cmd;
    logic [DATA_WIDTH-1:0] w_data     [CAPACITY];
    logic [DATA_WIDTH-1:0] w_sel_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_taken;

    // Handshake: take a new operation when the output register is free or draining
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_pos_x = CMP_W'(i_in.position);
    assign w_cnt_x = CMP_W'(r_count);
    assign w_full  = (r_count >= CNT_W'(CAPACITY));

    // Operation decode, status and new count
    always_comb begin
        w_cmd.ins   = 1'b0;
        w_cmd.rem   = 1'b0;
        w_cmd.pos   = IDX_W'(i_in.position);
        w_cmd.value = DATA_WIDTH'(i_in.value);
        n_status    = ST_OK;
        n_count     = r_count;
        case (i_in.op)
            OP_APPEND: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    w_cmd.pos = IDX_W'(r_count);
                    n_count   = r_count + 1'b1;
                end
            end
            OP_INSERT: begin
                if (w_pos_x > w_cnt_x) begin
                    n_status = ST_RANGE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_cmd.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            OP_REMOVE: begin
                if (w_pos_x >= w_cnt_x) begin
                    n_status = ST_RANGE;
                end else begin
                    w_cmd.rem = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign w_do = w_accept;

    // Chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_left;
        logic [DATA_WIDTH-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_data[g];
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_data[g];
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        ilir_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (IDX_W'(g)),
            .i_en       (w_do),
            .i_cmd      (w_cmd),
            .i_left     (w_left),
            .i_right    (w_right),
            .o_data     (w_data[g]),
            .o_sel_data (w_sel_data[g])
        );
    end

    // Removed value: OR of the one selected cell
    always_comb begin
        w_taken = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_taken = w_taken | w_sel_data[k];
        end
        n_removed = w_cmd.rem ? VALUE_W'(w_taken) : '0;
    end

    // Count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status  <= n_status;
            r_removed <= n_removed;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.removed_value = r_removed;
    assign o_out.length        = LEN_W'(r_count);

endmodule

// ===== rtl/ilir_cell.sv =====
// One storage cell of the list chain: holds one element and shifts with its neighbours.
module ilir_cell (
    input  logic                           i_clk,
    input  logic [ilir_pkg::IDX_W-1:0]      i_index,
    input  logic                           i_en,
    input  ilir_pkg::t_cell_cmd            i_cmd,
    input  logic [ilir_pkg::DATA_WIDTH-1:0] i_left,
    input  logic [ilir_pkg::DATA_WIDTH-1:0] i_right,
    output logic [ilir_pkg::DATA_WIDTH-1:0] o_data,
    output logic [ilir_pkg::DATA_WIDTH-1:0] o_sel_data
);
    import ilir_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Insert: load at the position, take from the left above it.
    // Remove: take from the right at and above the position.
    always_comb begin
        n_data = r_data;
        if (i_en && i_cmd.ins) begin
            if (i_index == i_cmd.pos) begin
                n_data = i_cmd.value;
            end else if (i_index > i_cmd.pos) begin
                n_data = i_left;
            end
        end else if (i_en && i_cmd.rem) begin
            if (i_index >= i_cmd.pos) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data     = r_data;
    // Contribution to the removed-value OR tree
    assign o_sel_data = (i_index == i_cmd.pos) ? r_data : '0;

endmodule
